/* rtl/ddo_pkg.sv */
package ddo_pkg;

  // Parameter defaults
  localparam int COUNT_BITS_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 24;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TPM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MWO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXSTEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CART    = 3'd4;

  // Register reset values
  localparam logic [31:0] TPM_RST     = 32'd65536000;
  localparam logic [30:0] TRACK_RST   = 31'd19661;
  localparam logic [30:0] MAXSTEP_RST = 31'd1000;

  // Arithmetic constants
  localparam logic signed [33:0] BAM_PER_RAD = 34'sd683565276;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [31:0] pose_x_in;
    logic signed [31:0] pose_y_in;
    logic        [31:0] heading_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [31:0] heading;
    logic               skipped;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  // CORDIC arctangent steps, binary angle
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Clamp to +-1.0 in Q1.30
  function automatic logic signed [31:0] clamp_q30(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd1073741824) r = 32'sd1073741824;
    else if (v < -66'sd1073741824) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Saturated signed Q16.16 travel from a quotient magnitude
  function automatic logic signed [31:0] meters(input logic [63:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (q > 64'd2147483648) r = 32'sh80000000;
      else r = 32'(-q);
    end else begin
      if (q > 64'd2147483647) r = 32'sh7FFFFFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ddo_div.sv */
module ddo_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ddo_pkg::div_req_t req,
  output ddo_pkg::div_rsp_t rsp
);
  import ddo_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [32:0] den_r;
  logic [33:0] trial;
  logic        ge;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_r, q_r[63]};
  assign ge    = trial >= {1'b0, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= ge ? 33'(trial - {1'b0, den_r}) : trial[32:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

/* rtl/differential_drive_odometry.sv */
// Differential-drive wheel odometry, Q16.16 pose with a 32-bit binary heading.
// Input channel (in_valid/in_stall/in_data): one item per odometry tick, either
// a pair of absolute encoder counts (opcode 0) or a pose to load (opcode 1).
// Result channel (out_valid/out_stall/out_data): exactly one result per item,
// holding the pose after that item and a skip flag for oversized count steps.
// Configuration (cfg_we/cfg_index/cfg_wdata): write-only registers, to be written
// only while the block is idle; the block itself does not enforce this.
// A pose load or a skipped sample goes straight from idle to the output state.
// In a full sample the 64-step shared restoring divider runs up to four times
// per item (left and right travel, heading change, turn radius) and the shared
// CORDIC stage runs up to twice. One multiplier is shared as well.
// The block takes one item at a time: in_stall is high while an item is in
// work. The result sits in an output register; a new item is accepted while
// it waits, and the next result waits for the receiver if it is still stalled.
// Synchronous reset clears the pose, the stored counts and the registers to
// their defaults.
module differential_drive_odometry #(
  parameter int COUNT_BITS   = ddo_pkg::COUNT_BITS_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ddo_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ddo_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_wdata
);
  import ddo_pkg::*;

  // Sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DLS  = 5'd1;
  localparam logic [4:0] S_DLW  = 5'd2;
  localparam logic [4:0] S_DRS  = 5'd3;
  localparam logic [4:0] S_DRW  = 5'd4;
  localparam logic [4:0] S_THM  = 5'd5;
  localparam logic [4:0] S_THS  = 5'd6;
  localparam logic [4:0] S_THW  = 5'd7;
  localparam logic [4:0] S_CLD  = 5'd8;
  localparam logic [4:0] S_CIT  = 5'd9;
  localparam logic [4:0] S_MOX  = 5'd10;
  localparam logic [4:0] S_MSW  = 5'd11;
  localparam logic [4:0] S_RS   = 5'd12;
  localparam logic [4:0] S_RW   = 5'd13;
  localparam logic [4:0] S_MOY  = 5'd14;
  localparam logic [4:0] S_OYW  = 5'd15;
  localparam logic [4:0] S_MR1  = 5'd16;
  localparam logic [4:0] S_MR2  = 5'd17;
  localparam logic [4:0] S_MR3  = 5'd18;
  localparam logic [4:0] S_MR4  = 5'd19;
  localparam logic [4:0] S_MR5  = 5'd20;
  localparam logic [4:0] S_OUT  = 5'd21;

  // Configuration registers
  logic [31:0]        tpm_r;
  logic [30:0]        track_r;
  logic signed [31:0] mwo_r;
  logic [30:0]        maxstep_r;
  logic               cart_r;

  // Architectural state
  logic [COUNT_BITS-1:0] last_l_r, last_r_r;
  logic signed [31:0]    acc_x_r, acc_y_r;
  logic [31:0]           acc_h_r;

  // Control
  logic [4:0] state_r, state_nxt;
  logic       out_valid_r;
  out_item_t  out_r;
  logic       skip_r;
  logic       cpass_r;
  logic       cflip_r;
  logic [5:0] ci_r;

  // Datapath registers
  logic [31:0]        lmag_r, rmag_r;
  logic               lneg_r, rneg_in_r;
  logic signed [31:0] dlm_r, drm_r;
  logic signed [63:0] dth_r;
  logic               thneg_r;
  logic               rneg_r;
  logic signed [31:0] r_r;
  logic signed [31:0] offx_r, offy_r;
  logic signed [63:0] p1_r;
  logic signed [34:0] dx_r;
  logic signed [63:0] mul_r;
  logic signed [33:0] cx_r, cy_r, cz_r;

  // Sample differences
  logic [COUNT_BITS-1:0] ul, ur;
  logic signed [32:0]    dl_w, dr_w;
  logic [31:0]           dl_mag, dr_mag;
  logic                  over;
  logic                  in_fire;

  assign in_fire = in_valid && !in_stall;
  assign ul      = in_data.left_count[COUNT_BITS-1:0] - last_l_r;
  assign ur      = in_data.right_count[COUNT_BITS-1:0] - last_r_r;
  assign dl_w    = 33'(signed'(ul));
  assign dr_w    = 33'(signed'(ur));
  assign dl_mag  = dl_w[32] ? 32'(-dl_w) : dl_w[31:0];
  assign dr_mag  = dr_w[32] ? 32'(-dr_w) : dr_w[31:0];
  assign over    = (dl_mag > {1'b0, maxstep_r}) || (dr_mag > {1'b0, maxstep_r});

  // Wheel travel sum and difference
  logic signed [32:0] dd, ds;
  logic [32:0]        dd_mag;
  logic [31:0]        half;
  assign dd     = 33'(dlm_r) - 33'(drm_r);
  assign ds     = 33'(dlm_r) + 33'(drm_r);
  assign dd_mag = dd[32] ? 33'(-dd) : 33'(dd);
  assign half   = dth_r[32:1];

  // Shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req = '0;
    case (state_r)
      S_DLS: begin
        div_req.start = (tpm_r != '0);
        div_req.num   = {lmag_r, 32'd0};
        div_req.den   = {1'b0, tpm_r};
      end
      S_DRS: begin
        div_req.start = (tpm_r != '0);
        div_req.num   = {rmag_r, 32'd0};
        div_req.den   = {1'b0, tpm_r};
      end
      S_THS: begin
        div_req.start = 1'b1;
        div_req.num   = abs64(mul_r);
        div_req.den   = {2'b00, track_r};
      end
      S_RS: begin
        div_req.start = 1'b1;
        div_req.num   = abs64(mul_r);
        div_req.den   = dd_mag;
      end
      default: div_req = '0;
    endcase
  end

  ddo_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Shared multiplier operands
  logic signed [33:0] mul_a, mul_b;
  logic signed [31:0] cor_s, cor_c;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_THM: begin mul_a = 34'(dd);     mul_b = BAM_PER_RAD;                end
      S_MOX: begin mul_a = 34'(cor_s);  mul_b = 34'(mwo_r);                 end
      S_MSW: begin mul_a = 34'(cor_s);  mul_b = signed'({3'b000, track_r}); end
      S_MOY: begin mul_a = 34'(ds);     mul_b = 34'(r_r);                   end
      S_MR1: begin mul_a = 34'(offy_r); mul_b = 34'(cor_c);                 end
      S_MR2: begin mul_a = 34'(offx_r); mul_b = 34'(cor_s);                 end
      S_MR3: begin mul_a = 34'(offx_r); mul_b = 34'(cor_c);                 end
      S_MR4: begin mul_a = 34'(offy_r); mul_b = 34'(cor_s);                 end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // CORDIC stage and its result
  logic signed [33:0] xs, ys, at;
  logic signed [33:0] cx_f, cy_f;
  logic [31:0]        ang, ang_m, ang2;
  logic               aflip;

  assign xs    = cx_r >>> ci_r[4:0];
  assign ys    = cy_r >>> ci_r[4:0];
  assign at    = signed'({2'b00, atan_bam(ci_r[4:0])});
  assign cx_f  = cflip_r ? -cx_r : cx_r;
  assign cy_f  = cflip_r ? -cy_r : cy_r;
  assign cor_c = clamp_q30(66'(cx_f));
  assign cor_s = clamp_q30(66'(cy_f));
  assign ang   = cpass_r ? acc_h_r + half : half;
  assign ang_m = ang - 32'h40000000;
  assign aflip = !ang_m[31];
  assign ang2  = aflip ? {~ang[31], ang[30:0]} : ang;

  // Rotation sums
  logic signed [64:0] dsum, dsub;
  logic signed [34:0] dy_w;
  logic signed [65:0] rq;
  assign dsub = 65'(p1_r) - 65'(mul_r);
  assign dsum = 65'(p1_r) + 65'(mul_r);
  assign dy_w = 35'(dsum >>> 30);
  assign rq   = rneg_r ? -signed'({2'b00, div_rsp.quot}) : signed'({2'b00, div_rsp.quot});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) begin
        state_nxt = (in_data.opcode || over) ? S_OUT : S_DLS;
      end
      S_DLS: state_nxt = (tpm_r == '0) ? S_DRS : S_DLW;
      S_DLW: if (div_rsp.done) state_nxt = S_DRS;
      S_DRS: state_nxt = (tpm_r == '0) ? S_THM : S_DRW;
      S_DRW: if (div_rsp.done) state_nxt = S_THM;
      S_THM: state_nxt = (track_r == '0) ? S_CLD : S_THS;
      S_THS: state_nxt = S_THW;
      S_THW: if (div_rsp.done) state_nxt = S_CLD;
      S_CLD: state_nxt = S_CIT;
      S_CIT: if (ci_r == 6'(CORDIC_STEPS - 1)) state_nxt = cpass_r ? S_MR1 : S_MOX;
      S_MOX: state_nxt = S_MSW;
      S_MSW: state_nxt = S_RS;
      S_RS:  state_nxt = S_RW;
      S_RW:  if (div_rsp.done) state_nxt = S_MOY;
      S_MOY: state_nxt = S_OYW;
      S_OYW: state_nxt = S_CLD;
      S_MR1: state_nxt = S_MR2;
      S_MR2: state_nxt = S_MR3;
      S_MR3: state_nxt = S_MR4;
      S_MR4: state_nxt = S_MR5;
      S_MR5: state_nxt = S_OUT;
      S_OUT: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r     <= TPM_RST;
      track_r   <= TRACK_RST;
      mwo_r     <= '0;
      maxstep_r <= MAXSTEP_RST;
      cart_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TPM:     tpm_r     <= cfg_wdata;
        CFG_TRACK:   track_r   <= cfg_wdata[30:0];
        CFG_MWO:     mwo_r     <= signed'(cfg_wdata);
        CFG_MAXSTEP: maxstep_r <= cfg_wdata[30:0];
        CFG_CART:    cart_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer, pose state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_l_r    <= '0;
      last_r_r    <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
      skip_r      <= 1'b0;
      cpass_r     <= 1'b0;
      ci_r        <= '0;
    end else begin
      state_r <= state_nxt;
      // result register: load on completion, clear on transfer
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_fire) begin
          skip_r <= !in_data.opcode && over;
          if (in_data.opcode) begin
            acc_x_r <= cart_r ? in_data.pose_y_in : in_data.pose_x_in;
            acc_y_r <= cart_r ? in_data.pose_x_in : in_data.pose_y_in;
            acc_h_r <= in_data.heading_in;
          end else begin
            last_l_r  <= in_data.left_count[COUNT_BITS-1:0];
            last_r_r  <= in_data.right_count[COUNT_BITS-1:0];
            lmag_r    <= dl_mag;
            rmag_r    <= dr_mag;
            lneg_r    <= dl_w[32];
            rneg_in_r <= dr_w[32];
          end
        end
        S_DLS: if (tpm_r == '0) dlm_r <= '0;
        S_DLW: if (div_rsp.done) dlm_r <= meters(div_rsp.quot, lneg_r);
        S_DRS: if (tpm_r == '0) drm_r <= '0;
        S_DRW: if (div_rsp.done) drm_r <= meters(div_rsp.quot, rneg_in_r);
        S_THM: if (track_r == '0) begin
          // no track width: straight move
          dth_r   <= '0;
          offx_r  <= '0;
          offy_r  <= drm_r;
          cpass_r <= 1'b1;
        end
        S_THS: thneg_r <= mul_r[63];
        S_THW: if (div_rsp.done) begin
          dth_r <= thneg_r ? -signed'(div_rsp.quot) : signed'(div_rsp.quot);
          if (div_rsp.quot == '0) begin
            offx_r  <= '0;
            offy_r  <= drm_r;
            cpass_r <= 1'b1;
          end else begin
            cpass_r <= 1'b0;
          end
        end
        S_CLD: begin
          // fold the angle into the right half-plane
          cx_r    <= CORDIC_GAIN;
          cy_r    <= '0;
          cz_r    <= 34'(signed'(ang2));
          cflip_r <= aflip;
          ci_r    <= '0;
        end
        S_CIT: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + at;
          end
          ci_r <= ci_r + 6'd1;
        end
        S_MSW: offx_r <= sat32(66'(mul_r >>> 29));
        S_RS:  rneg_r <= mul_r[63] ^ dd[32];
        S_RW:  if (div_rsp.done) r_r <= clamp_q30(rq);
        S_OYW: begin
          offy_r  <= sat32(66'(mul_r >>> 30));
          cpass_r <= 1'b1;
        end
        S_MR2: p1_r <= mul_r;
        S_MR3: dx_r <= 35'(dsub >>> 30);
        S_MR4: p1_r <= mul_r;
        S_MR5: begin
          acc_x_r <= sat32(66'(acc_x_r) + 66'(dx_r));
          acc_y_r <= sat32(66'(acc_y_r) + 66'(dy_w));
          acc_h_r <= acc_h_r + dth_r[31:0];
        end
        S_OUT: if (!out_valid_r || !out_stall) begin
          out_r.pose_x  <= cart_r ? acc_y_r : acc_x_r;
          out_r.pose_y  <= cart_r ? acc_x_r : acc_y_r;
          out_r.heading <= acc_h_r;
          out_r.skipped <= skip_r;
        end
        default: ;
      endcase
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    mul_r <= 64'(mul_a * mul_b);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("result not presented after completion");

  a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CIT |-> ci_r < 6'(CORDIC_STEPS))
    else $error("CORDIC step count overran");

  a_load_not_skipped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.opcode) |=> !skip_r)
    else $error("pose load flagged as skipped");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_THW || state_r == S_RW) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

endmodule
